@@ rtl/spd_pkg.sv @@
`default_nettype none

package spd_pkg;

  localparam int DEPTH_BITS    = 18;
  localparam int DELAY_DEPTH   = 1 << DEPTH_BITS;
  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 8;
  localparam int POS_BITS      = DEPTH_BITS + FRAC_BITS;
  localparam int GAIN_BITS     = 16;
  localparam int FB_BITS       = 15;
  localparam int GAIN_FRAC     = 15;
  localparam int WIDE_BITS     = 48;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = POS_BITS;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(32768);
  localparam logic [FB_BITS-1:0]   FB_MAX   = FB_BITS'(29491);

  localparam logic [GAIN_BITS-1:0] BALANCE_RST  = GAIN_BITS'(8192);
  localparam logic [POS_BITS-1:0]  DELAY_RST    = POS_BITS'(1228800);
  localparam logic [FB_BITS-1:0]   FEEDBACK_RST = FB_BITS'(22938);
  localparam logic [GAIN_BITS-1:0] MIX_RST      = GAIN_BITS'(32768);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_BALANCE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIX      = 2'd3;

  localparam logic signed [WIDE_BITS-1:0] SMP_MAX =
    WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE_BITS-1:0] SMP_MIN = -SMP_MAX - WIDE_BITS'(64'sd1);

  // per-lane stage strobes driven by the sequencer
  typedef struct packed {
    logic rd;      // read both taps
    logic adv1;    // first products
    logic adv2;    // round, interpolate
    logic adv3;    // mix and feedback products
    logic wr;      // store write
    logic clr;     // store write of zero
    logic bypass;  // zero delay: raw passes through
  } spd_ctl_t;

  // round half up, then arithmetic shift
  function automatic logic signed [WIDE_BITS-1:0] rnd_shr(
    input logic signed [WIDE_BITS-1:0] v,
    input int unsigned                 sh
  );
    logic signed [WIDE_BITS-1:0] half;
    half = $signed(WIDE_BITS'(1) << (sh - 1));
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] c;
    if (v > SMP_MAX) begin
      c = SMP_MAX;
    end else if (v < SMP_MIN) begin
      c = SMP_MIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/spd_in_if.sv @@
`default_nettype none

interface spd_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [spd_pkg::SAMPLE_BITS-1:0]   in_left;
  logic signed [spd_pkg::SAMPLE_BITS-1:0]   in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

`default_nettype wire

@@ rtl/spd_out_if.sv @@
`default_nettype none

interface spd_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [spd_pkg::SAMPLE_BITS-1:0]   out_left;
  logic signed [spd_pkg::SAMPLE_BITS-1:0]   out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

@@ rtl/spd_lane.sv @@
`default_nettype none

// One channel: echo store, interpolated tap, input weight, wet/dry mix and
// the store value built from the other lane's tap.
module spd_lane (
  input  wire logic                                  clk,
  input  wire spd_pkg::spd_ctl_t                     ctl,
  input  wire logic [spd_pkg::DEPTH_BITS-1:0]        rd_addr0,
  input  wire logic [spd_pkg::DEPTH_BITS-1:0]        rd_addr1,
  input  wire logic [spd_pkg::DEPTH_BITS-1:0]        wr_addr,
  input  wire logic signed [spd_pkg::SAMPLE_BITS-1:0] raw,
  input  wire logic [spd_pkg::GAIN_BITS-1:0]         in_gain,
  input  wire logic [spd_pkg::FRAC_BITS-1:0]         frac,
  input  wire logic [spd_pkg::GAIN_BITS-1:0]         mix,
  input  wire logic [spd_pkg::FB_BITS-1:0]           fb,
  input  wire logic signed [spd_pkg::SAMPLE_BITS-1:0] cross_dl,
  output logic signed [spd_pkg::SAMPLE_BITS-1:0]     dl,
  output logic signed [spd_pkg::SAMPLE_BITS-1:0]     result
);

  localparam int SB = spd_pkg::SAMPLE_BITS;
  localparam int W  = spd_pkg::WIDE_BITS;
  localparam int PIN_BITS  = SB + spd_pkg::GAIN_BITS + 2;
  localparam int PINT_BITS = SB + 1 + spd_pkg::FRAC_BITS + 1;
  localparam int PMIX_BITS = SB + 1 + spd_pkg::GAIN_BITS + 2;
  localparam int PFB_BITS  = SB + spd_pkg::FB_BITS + 1;

  logic signed [SB-1:0] mem [spd_pkg::DELAY_DEPTH];

  logic signed [SB-1:0]        d1_r, d2_r, raw_r;
  logic signed [PIN_BITS-1:0]  pin_r, pin_nxt;
  logic signed [PINT_BITS-1:0] pint_r, pint_nxt;
  logic signed [SB-1:0]        inl_r, inl_nxt;
  logic signed [SB-1:0]        dl_r, dl_nxt;
  logic signed [PMIX_BITS-1:0] pmix_r, pmix_nxt;
  logic signed [PFB_BITS-1:0]  pfb_r, pfb_nxt;
  logic signed [SB:0]          diff, dmi;
  logic signed [W-1:0]         dl_sum;
  logic signed [SB-1:0]        mixed, wdata;

  always_comb begin
    diff     = (SB+1)'(d2_r) - (SB+1)'(d1_r);
    pin_nxt  = PIN_BITS'(raw_r) * PIN_BITS'($signed({2'b00, in_gain}));
    pint_nxt = PINT_BITS'(diff) * PINT_BITS'($signed({1'b0, frac}));
    dl_sum   = W'(d1_r) + spd_pkg::rnd_shr(W'(pint_r), spd_pkg::FRAC_BITS);
    inl_nxt  = spd_pkg::sat_smp(spd_pkg::rnd_shr(W'(pin_r), spd_pkg::GAIN_FRAC));
    dl_nxt   = dl_sum[SB-1:0];
    dmi      = (SB+1)'(dl_r) - (SB+1)'(inl_r);
    pmix_nxt = PMIX_BITS'(dmi) * PMIX_BITS'($signed({2'b00, mix}));
    pfb_nxt  = PFB_BITS'(cross_dl) * PFB_BITS'($signed({1'b0, fb}));
    mixed    = spd_pkg::sat_smp(W'(inl_r) + spd_pkg::rnd_shr(W'(pmix_r), spd_pkg::GAIN_FRAC));
    wdata    = spd_pkg::sat_smp(W'(inl_r) + spd_pkg::rnd_shr(W'(pfb_r), spd_pkg::GAIN_FRAC));
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= ctl.clr ? '0 : wdata;
    end
    if (ctl.rd) begin
      d1_r  <= mem[rd_addr0];
      d2_r  <= mem[rd_addr1];
      raw_r <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      pin_r  <= pin_nxt;
      pint_r <= pint_nxt;
    end
    if (ctl.adv2) begin
      inl_r <= inl_nxt;
      dl_r  <= dl_nxt;
    end
    if (ctl.adv3) begin
      pmix_r <= pmix_nxt;
      pfb_r  <= pfb_nxt;
    end
  end

  assign dl     = dl_r;
  assign result = ctl.bypass ? raw_r : mixed;

endmodule

`default_nettype wire

@@ rtl/stereo_ping_pong_delay.sv @@
// An accepted pair passes MUL1, RND, MUL2, then waits in DONE until the output
//   register is free or being emptied; only one pair is taken at a time by the
//   five-step sequencer, sharing one read/write pass over both echo stores.
// Reset (synchronous, rst_n low): configuration to defaults, write index zero,
//   then a clearing pass over all 262144 entries zeroes both stores; no input
//   transaction is accepted during it, configuration writes are.
`default_nettype none

module stereo_ping_pong_delay (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  spd_in_if.sink                                  in_ch,
  spd_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [spd_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  wire logic [spd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DB = spd_pkg::DEPTH_BITS;
  localparam int SB = spd_pkg::SAMPLE_BITS;
  localparam int FB = spd_pkg::FRAC_BITS;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  // configuration; gains and feedback clamped on write
  logic [spd_pkg::GAIN_BITS-1:0] bal_r, mix_r;
  logic [spd_pkg::POS_BITS-1:0]  dly_r;
  logic [spd_pkg::FB_BITS-1:0]   fb_r;

  logic [DB-1:0] wr_idx_r;
  logic [DB-1:0] clr_addr_r;
  logic          clr_busy_r;
  logic          zero_r;
  logic [FB-1:0] frac_r;

  logic                       out_valid_r;
  logic signed [SB-1:0]       out_left_r, out_right_r;

  logic [spd_pkg::POS_BITS-1:0] rd_pos;
  logic [DB-1:0]                rd_addr0, rd_addr1, wr_addr;
  logic                         in_acc, done_go;
  spd_pkg::spd_ctl_t            ctl;
  logic signed [SB-1:0]         dl_left, dl_right, res_left, res_right;
  logic [spd_pkg::GAIN_BITS-1:0] left_gain;

  // Read position trails the write position by the fractional delay; the
  // subtraction wraps at the store size times 256 by itself.
  always_comb begin
    rd_pos   = {wr_idx_r, {FB{1'b0}}} - dly_r;
    rd_addr0 = rd_pos[spd_pkg::POS_BITS-1:FB];
    rd_addr1 = rd_addr0 + DB'(1);
    wr_addr  = clr_busy_r ? clr_addr_r : wr_idx_r;
    left_gain = spd_pkg::GAIN_ONE - bal_r;
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !clr_busy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  // finish only when the output register is free or being emptied
  assign done_go     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl.rd     = in_acc;
    ctl.adv1   = (state_r == ST_MUL1);
    ctl.adv2   = (state_r == ST_RND);
    ctl.adv3   = (state_r == ST_MUL2);
    ctl.clr    = clr_busy_r;
    // zero delay stores nothing
    ctl.wr     = clr_busy_r || (done_go && !zero_r);
    ctl.bypass = zero_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DONE;
      ST_DONE: if (done_go) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Left and right lanes; each lane's tap feeds the other's store (ping-pong).
  spd_lane u_lane_left (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .wr_addr  (wr_addr),
    .raw      (in_ch.in_left),
    .in_gain  (left_gain),
    .frac     (frac_r),
    .mix      (mix_r),
    .fb       (fb_r),
    .cross_dl (dl_right),
    .dl       (dl_left),
    .result   (res_left)
  );

  spd_lane u_lane_right (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .wr_addr  (wr_addr),
    .raw      (in_ch.in_right),
    .in_gain  (bal_r),
    .frac     (frac_r),
    .mix      (mix_r),
    .fb       (fb_r),
    .cross_dl (dl_left),
    .dl       (dl_right),
    .result   (res_right)
  );

  // configuration registers: out-of-range gains saturate on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bal_r <= spd_pkg::BALANCE_RST;
      dly_r <= spd_pkg::DELAY_RST;
      fb_r  <= spd_pkg::FEEDBACK_RST;
      mix_r <= spd_pkg::MIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spd_pkg::CFG_BALANCE: begin
          bal_r <= (cfg_data[spd_pkg::GAIN_BITS-1:0] > spd_pkg::GAIN_ONE) ?
                   spd_pkg::GAIN_ONE : cfg_data[spd_pkg::GAIN_BITS-1:0];
        end
        spd_pkg::CFG_DELAY: begin
          dly_r <= cfg_data[spd_pkg::POS_BITS-1:0];
        end
        spd_pkg::CFG_FEEDBACK: begin
          fb_r <= (cfg_data[spd_pkg::FB_BITS-1:0] > spd_pkg::FB_MAX) ?
                  spd_pkg::FB_MAX : cfg_data[spd_pkg::FB_BITS-1:0];
        end
        spd_pkg::CFG_MIX: begin
          mix_r <= (cfg_data[spd_pkg::GAIN_BITS-1:0] > spd_pkg::GAIN_ONE) ?
                   spd_pkg::GAIN_ONE : cfg_data[spd_pkg::GAIN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer, write index and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wr_idx_r   <= '0;
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (done_go) begin
        wr_idx_r <= wr_idx_r + DB'(1);
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + DB'(1);
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // tap fraction and zero-delay flag, latched with the transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      zero_r <= (rd_addr0 == wr_idx_r);
      frac_r <= rd_pos[FB-1:0];
    end
  end

  // output register: hold until taken, reload when the sequencer finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_left_r;
  assign out_ch.out_right = out_right_r;

  // a transaction moves the sequencer out of idle on the next edge
  a_acc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_MUL1)
    else $error("sequencer did not start after accept");

  // write index advances by one per finished transaction
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> wr_idx_r == $past(wr_idx_r) + DB'(1))
    else $error("write index did not advance");

  // no result can appear while the stores are being cleared
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !out_valid_r && state_r == ST_IDLE)
    else $error("activity during clearing pass");

  // zero delay never writes the store
  a_bypass_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr && !clr_busy_r) |-> !zero_r && done_go)
    else $error("store written on zero delay");

endmodule

`default_nettype wire
